[hw/rtl/dhis_pkg.sv]
// ----------------------------------------------------------------------------
// Double hash integer set package
// Field widths, operation and status codes, and the slot entry type.
// ----------------------------------------------------------------------------
package dhis_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;

  localparam int unsigned KEY_W     = 31;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned TSIZE_W   = 11;
  localparam int unsigned PRIME_W   = 10;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned SHRINK_SHIFT = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PRIME = 1'b1;

  typedef struct packed {
    logic             used;
    logic             tomb;
    logic [KEY_W-1:0] key;
  } slot_t;

endpackage

[hw/rtl/double_hash_int_set.sv]
// ----------------------------------------------------------------------------
// Double hash integer set
// Open-addressing key set with double hashing, held in one slot memory.
// ----------------------------------------------------------------------------
// Steps: key mod size and key mod prime are reduced side by side, one key bit a
// cycle, in two remainder units (S_DIVA); the step is then reduced mod the size
// (S_DIVB); each probe reads memory (S_READ), then compares and writes back
// (S_EVAL). An unused opcode answers NOTFOUND from idle. One operation at a
// time; done is a one-cycle strobe. After reset a clearing pass over every slot
// keeps busy high; configuration writes are taken during it.
module double_hash_int_set #(
  parameter int unsigned CAPACITY = dhis_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dhis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dhis_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic [dhis_pkg::OP_W-1:0]       op,
  input  logic [dhis_pkg::KEY_W-1:0]      key_value,
  output logic                            done,
  output logic [dhis_pkg::STATUS_W-1:0]   status,
  output logic [dhis_pkg::SLOT_W-1:0]     slot_index,
  output logic [dhis_pkg::COUNT_W-1:0]    probe_count,
  output logic [dhis_pkg::COUNT_W-1:0]    live_count,
  output logic                            shrink_hint
);
  import dhis_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned TW = (CW > TSIZE_W) ? CW : TSIZE_W;
  localparam int unsigned RW = TW + 1;
  localparam int unsigned BW = $clog2(KEY_W);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIVA  = 3'd2;
  localparam logic [2:0] S_DIVB  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_EVAL  = 3'd5;

  logic [2:0]         state;
  logic [TSIZE_W-1:0] table_size;
  logic [PRIME_W-1:0] step_prime;
  logic [OP_W-1:0]    op_q;
  logic [KEY_W-1:0]   key_q;
  logic [KEY_W-1:0]   dividend;
  logic [BW-1:0]      bit_idx;
  logic [RW-1:0]      rem_s;
  logic [RW-1:0]      rem_p;
  logic [AW-1:0]      cur;
  logic [AW-1:0]      stepr;
  logic [CW-1:0]      probe_j;
  logic [CW-1:0]      total;
  logic [AW-1:0]      clr_addr;

  slot_t              mem [CAPACITY];
  slot_t              rdata;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  slot_t              mem_wdata;

  logic [TW-1:0]      tsz;
  logic [TW-1:0]      psz;
  logic [TW-1:0]      size_use;
  logic [TW-1:0]      p_use;
  logic [RW-1:0]      rem_s_next;
  logic [RW-1:0]      rem_p_next;
  logic [TW-1:0]      jn;
  logic               last;
  logic               hit;
  logic               advance;
  logic [RW-1:0]      sum;
  logic [AW-1:0]      cur_next;
  logic [CW-1:0]      total_dec;

  function automatic logic [RW-1:0] rem_bit(input logic [RW-1:0] r, input logic b,
                                            input logic [TW-1:0] d);
    logic [RW-1:0] s;
    s = {r[RW-2:0], b};
    return (s >= {1'b0, d}) ? (s - {1'b0, d}) : s;
  endfunction

  always_comb begin
    tsz = TW'(table_size);
    psz = TW'(step_prime);
    if (tsz > TW'(CAPACITY)) begin
      size_use = TW'(CAPACITY);
    end else if (tsz < TW'(2)) begin
      size_use = TW'(2);
    end else begin
      size_use = tsz;
    end
    p_use = (psz < TW'(2)) ? TW'(2) : psz;
    rem_s_next = rem_bit(rem_s, dividend[bit_idx], size_use);
    rem_p_next = rem_bit(rem_p, dividend[bit_idx], p_use);
    jn = TW'(probe_j) + TW'(1);
    last = (jn == size_use);
    hit = rdata.used && !rdata.tomb && (rdata.key == key_q);
    advance = rdata.used && !last && ((op_q == OP_INSERT) || !hit);
    sum = RW'(cur) + RW'(stepr);
    if (sum >= RW'(size_use)) begin
      sum = sum - RW'(size_use);
    end
    cur_next = AW'(sum);
    total_dec = (total != '0) ? (total - CW'(1)) : total;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
    end else if (state == S_EVAL) begin
      if (op_q == OP_INSERT && !rdata.used) begin
        mem_we    = 1'b1;
        mem_wdata = '{used: 1'b1, tomb: 1'b0, key: key_q};
      end else if (op_q == OP_REMOVE && hit) begin
        mem_we    = 1'b1;
        mem_wdata = '{used: rdata.used, tomb: 1'b1, key: rdata.key};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[cur];
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      table_size  <= TSIZE_W'(1021);
      step_prime  <= PRIME_W'(1019);
      total       <= '0;
      clr_addr    <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TABLE_SIZE: table_size <= cfg_data[TSIZE_W-1:0];
          CFG_STEP_PRIME: step_prime <= cfg_data[PRIME_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(CAPACITY - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q     <= op;
            key_q    <= key_value;
            dividend <= key_value;
            bit_idx  <= BW'(KEY_W - 1);
            rem_s    <= '0;
            rem_p    <= '0;
            probe_j  <= '0;
            if (op == OP_INSERT || op == OP_SEARCH || op == OP_REMOVE) begin
              state <= S_DIVA;
            end else begin
              done        <= 1'b1;
              status      <= ST_NOTFOUND;
              slot_index  <= '0;
              probe_count <= '0;
              live_count  <= COUNT_W'(total);
              shrink_hint <= 1'b0;
            end
          end
        end
        S_DIVA: begin
          rem_s   <= rem_s_next;
          rem_p   <= rem_p_next;
          bit_idx <= bit_idx - BW'(1);
          if (bit_idx == '0) begin
            cur      <= AW'(rem_s_next);
            dividend <= KEY_W'(p_use - TW'(rem_p_next));
            bit_idx  <= BW'(PRIME_W - 1);
            rem_s    <= '0;
            state    <= S_DIVB;
          end
        end
        S_DIVB: begin
          rem_s   <= rem_s_next;
          bit_idx <= bit_idx - BW'(1);
          if (bit_idx == '0) begin
            stepr <= AW'(rem_s_next);
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          shrink_hint <= 1'b0;
          slot_index  <= '0;
          probe_count <= COUNT_W'(jn);
          live_count  <= COUNT_W'(total);
          if (op_q == OP_INSERT) begin
            if (!rdata.used) begin
              total       <= total + CW'(1);
              done        <= 1'b1;
              status      <= ST_OK;
              slot_index  <= SLOT_W'(cur);
              live_count  <= COUNT_W'(total + CW'(1));
              state       <= S_IDLE;
            end else if (last) begin
              done   <= 1'b1;
              status <= ST_FULL;
              state  <= S_IDLE;
            end
          end else begin
            if (!rdata.used || (!hit && last)) begin
              done   <= 1'b1;
              status <= ST_NOTFOUND;
              state  <= S_IDLE;
            end else if (hit) begin
              done       <= 1'b1;
              status     <= ST_OK;
              slot_index <= SLOT_W'(cur);
              state      <= S_IDLE;
              if (op_q == OP_REMOVE) begin
                total       <= total_dec;
                live_count  <= COUNT_W'(total_dec);
                shrink_hint <= (total_dec != '0) &&
                               (TW'(total_dec) < (size_use >> SHRINK_SHIFT));
              end
            end
          end
          if (advance) begin
            cur     <= cur_next;
            probe_j <= probe_j + CW'(1);
            state   <= S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/dhis_checker.sv]
// ----------------------------------------------------------------------------
// Double hash integer set checker
// Port-level assertions on reset, accept and result beats.
// ----------------------------------------------------------------------------
module dhis_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic [dhis_pkg::STATUS_W-1:0]  status,
  input logic [dhis_pkg::SLOT_W-1:0]    slot_index,
  input logic [dhis_pkg::COUNT_W-1:0]   probe_count,
  input logic                           shrink_hint
);
  import dhis_pkg::*;

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> busy) else $error("block not clearing after reset");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done)) else $error("accepted beat dropped");

  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (slot_index == '0 && !shrink_hint))
    else $error("full result carries a slot");

  a_found_probes: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OK) |-> (probe_count != '0))
    else $error("hit without a probe");

endmodule

bind double_hash_int_set dhis_checker u_dhis_checker (.*);
